/* rtl/svg_pkg.sv */
// Shared types, constants and arithmetic helpers of the sphere vertex generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package svg_pkg;

  localparam int unsigned GRID_MAX     = 1024;
  localparam int unsigned IDX_W        = 11;
  localparam int unsigned RAD_W        = 24;
  localparam int unsigned TEX_W        = 17;
  localparam int unsigned DIV_STEPS    = 17;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned XY_W         = 33;
  localparam int unsigned Z_W          = 26;
  localparam int unsigned TRIG_W       = 18;
  localparam int unsigned NRM_W        = 16;
  localparam int unsigned POS_W        = 24;
  localparam int unsigned WIDE_W       = 44;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic signed [XY_W-1:0] CORDIC_START = 33'sd652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

  // One lane of the restoring divider: partial remainder, dividend bits
  // still to be brought down, and the quotient built so far.
  typedef struct packed {
    logic [IDX_W-1:0]     rem;
    logic [DIV_STEPS-1:0] num;
    logic [TEX_W-1:0]     quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t u;
    div_lane_t v;
  } div_word_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } cordic_lane_t;

  typedef struct packed {
    cordic_lane_t     phi;
    cordic_lane_t     th;
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } cordic_word_t;

  // Arctangent of 2^-i in Q0.24 turns.
  function automatic logic signed [Z_W-1:0] atan_turns(input int unsigned step);
    logic signed [Z_W-1:0] a;
    case (step)
      0:  a = 26'sd2097152;
      1:  a = 26'sd1238021;
      2:  a = 26'sd654136;
      3:  a = 26'sd332050;
      4:  a = 26'sd166669;
      5:  a = 26'sd83416;
      6:  a = 26'sd41718;
      7:  a = 26'sd20860;
      8:  a = 26'sd10430;
      9:  a = 26'sd5215;
      10: a = 26'sd2608;
      11: a = 26'sd1304;
      12: a = 26'sd652;
      13: a = 26'sd326;
      14: a = 26'sd163;
      15: a = 26'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // A divisions register of zero acts as one; above the limit it clips.
  function automatic logic [IDX_W-1:0] eff_div(input logic [IDX_W-1:0] r);
    logic [IDX_W-1:0] d;
    if (r == '0) d = IDX_W'(1);
    else if (r > IDX_W'(GRID_MAX)) d = IDX_W'(GRID_MAX);
    else d = r;
    return d;
  endfunction

  function automatic logic signed [NRM_W-1:0] sat16(input logic signed [WIDE_W-1:0] a);
    logic signed [NRM_W-1:0] r;
    if (a > WIDE_W'(signed'(32767))) r = 16'sd32767;
    else if (a < -WIDE_W'(signed'(32768))) r = -16'sd32768;
    else r = a[NRM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [WIDE_W-1:0] a);
    logic signed [POS_W-1:0] r;
    if (a > WIDE_W'(signed'(8388607))) r = 24'sd8388607;
    else if (a < -WIDE_W'(signed'(8388608))) r = -24'sd8388608;
    else r = a[POS_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/svg_if.sv */
// Valid/ready channel interfaces for grid points in and vertices out.
// Depends on svg_pkg for field widths.
`timescale 1ns / 1ps

interface svg_in_if import svg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] col_index;
  logic [IDX_W-1:0] row_index;

  modport source (output valid, col_index, row_index, input ready);
  modport sink   (input valid, col_index, row_index, output ready);
endinterface

interface svg_out_if import svg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;
  logic signed [NRM_W-1:0] norm_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic signed [NRM_W-1:0] tan_x;
  logic signed [NRM_W-1:0] tan_z;
  logic signed [NRM_W-1:0] binorm_y;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  tan_x, tan_z, binorm_y, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  tan_x, tan_z, binorm_y, output ready);
endinterface

/* rtl/svg_div_cell.sv */
// One cell of the pipelined restoring divider: one quotient bit for u and v.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_div_cell import svg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  div_word_t        up_data,
  input  logic [IDX_W-1:0] div_u,
  input  logic [IDX_W-1:0] div_v,
  output logic             dn_valid,
  input  logic             dn_ready,
  output div_word_t        dn_data
);

  logic      valid_r;
  div_word_t data_r;
  div_word_t data_nxt;

  function automatic div_lane_t div_step(input div_lane_t a, input logic [IDX_W-1:0] d);
    div_lane_t      r;
    logic [IDX_W:0] rem2;
    logic [IDX_W:0] diff;
    logic           ge;
    rem2   = {a.rem, a.num[DIV_STEPS-1]};
    diff   = rem2 - {1'b0, d};
    ge     = (rem2 >= {1'b0, d});
    r.rem  = ge ? diff[IDX_W-1:0] : rem2[IDX_W-1:0];
    r.num  = {a.num[DIV_STEPS-2:0], 1'b0};
    r.quo  = {a.quo[TEX_W-2:0], ge};
    return r;
  endfunction

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.u = div_step(up_data.u, div_u);
    data_nxt.v = div_step(up_data.v, div_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/svg_cordic_cell.sv */
// One rotation-mode CORDIC cell, applied to the longitude and latitude lanes.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_cordic_cell import svg_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  cordic_word_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output cordic_word_t dn_data
);

  logic         valid_r;
  cordic_word_t data_r;
  cordic_word_t data_nxt;

  function automatic cordic_lane_t rotate(input cordic_lane_t a);
    cordic_lane_t           r;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    xs = a.x >>> STEP;
    ys = a.y >>> STEP;
    at = atan_turns(STEP);
    r.flip = a.flip;
    if (a.z >= 0) begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - at;
    end else begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + at;
    end
    return r;
  endfunction

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt     = up_data;
    data_nxt.phi = rotate(up_data.phi);
    data_nxt.th  = rotate(up_data.th);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/sphere_vertex_generator_core.sv */
// Top level of the UV sphere vertex generator: input register, divider and
// CORDIC cell chains, product stages and output register. Depends on svg_pkg,
// svg_if, svg_div_cell and svg_cordic_cell.
`timescale 1ns / 1ps

// The block takes one grid point (col_index, row_index) per cycle while its
// input is ready, and returns one vertex per item, in order. Each item
// passes through 38 registers, formed by the chains of cells: one input
// register, seventeen divider cells that each resolve one bit of u and v,
// one phase stage, sixteen CORDIC cells that each perform one rotation for
// the longitude and the latitude, a rounding stage, a normal product stage
// and the position product stage, which is also the output register. Every
// stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so the block keeps taking items while a finished vertex
// waits at the output, until every stage is full, and gaps between items
// close up under back pressure.
// Configuration (radius, grid_rows, grid_cols) must only be written while
// no item is in flight; the divider cells read the grid sizes directly.

module sphere_vertex_generator_core import svg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  svg_in_if.sink               in_ch,
  svg_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [RAD_W-1:0] radius_r;
  logic [IDX_W-1:0] rows_r;
  logic [IDX_W-1:0] cols_r;
  logic [IDX_W-1:0] rows_eff;
  logic [IDX_W-1:0] cols_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(65536);
      rows_r   <= IDX_W'(100);
      cols_r   <= IDX_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_wdata;
        CFG_ROWS:   rows_r   <= cfg_wdata[IDX_W-1:0];
        CFG_COLS:   cols_r   <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff = eff_div(rows_r);
  assign cols_eff = eff_div(cols_r);

  // Input register: clamp the indices to the grid and form the dividend
  // index*65536 + divisor/2. Its top bits are the first partial remainder.
  logic             f_v_r;
  div_word_t        f_d_r;
  div_word_t        f_d_nxt;
  logic [IDX_W-1:0] col_c;
  logic [IDX_W-1:0] row_c;
  logic             f_rdy;

  localparam int unsigned DIV_LINKS = DIV_STEPS + 1;
  logic      dv   [DIV_LINKS];
  logic      drdy [DIV_LINKS];
  div_word_t dd   [DIV_LINKS];

  assign col_c = (in_ch.col_index > cols_eff) ? cols_eff : in_ch.col_index;
  assign row_c = (in_ch.row_index > rows_eff) ? rows_eff : in_ch.row_index;

  always_comb begin
    f_d_nxt.u.rem = {1'b0, col_c[IDX_W-1:1]};
    f_d_nxt.u.num = {col_c[0], {(DIV_STEPS - IDX_W){1'b0}}, cols_eff[IDX_W-1:1]};
    f_d_nxt.u.quo = '0;
    f_d_nxt.v.rem = {1'b0, row_c[IDX_W-1:1]};
    f_d_nxt.v.num = {row_c[0], {(DIV_STEPS - IDX_W){1'b0}}, rows_eff[IDX_W-1:1]};
    f_d_nxt.v.quo = '0;
  end

  assign f_rdy       = !f_v_r || drdy[0];
  assign in_ch.ready = f_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_rdy) begin
      f_v_r <= in_ch.valid;
    end
    if (f_rdy && in_ch.valid) begin
      f_d_r <= f_d_nxt;
    end
  end

  // Divider chain: u = col/cols and v = row/rows, rounded to nearest.
  assign dv[0] = f_v_r;
  assign dd[0] = f_d_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    svg_div_cell u_div_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[k]),
      .up_ready (drdy[k]),
      .up_data  (dd[k]),
      .div_u    (cols_eff),
      .div_v    (rows_eff),
      .dn_valid (dv[k+1]),
      .dn_ready (drdy[k+1]),
      .dn_data  (dd[k+1])
    );
  end

  // Phase stage: phases in turns, folded into the half turn around zero.
  localparam int unsigned COR_LINKS = CORDIC_STEPS + 1;
  logic         cv   [COR_LINKS];
  logic         crdy [COR_LINKS];
  cordic_word_t cd   [COR_LINKS];

  logic         p_v_r;
  cordic_word_t p_d_r;
  cordic_word_t p_d_nxt;
  logic         p_rdy;
  logic [23:0]  phi_ph;
  logic [23:0]  th_ph;

  function automatic cordic_lane_t fold(input logic [23:0] ph);
    cordic_lane_t          r;
    logic signed [Z_W-1:0] z;
    z      = Z_W'(signed'(ph));
    r.x    = CORDIC_START;
    r.y    = '0;
    r.flip = 1'b0;
    if (z > Z_W'(signed'(1 << 22))) begin
      z      = z - Z_W'(signed'(1 << 23));
      r.flip = 1'b1;
    end else if (z < -Z_W'(signed'(1 << 22))) begin
      z      = z + Z_W'(signed'(1 << 23));
      r.flip = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  assign phi_ph = {dd[DIV_STEPS].u.quo[15:0], 8'b0};
  assign th_ph  = {dd[DIV_STEPS].v.quo, 7'b0} - 24'h400000;

  always_comb begin
    p_d_nxt.phi = fold(phi_ph);
    p_d_nxt.th  = fold(th_ph);
    p_d_nxt.u   = dd[DIV_STEPS].u.quo;
    p_d_nxt.v   = dd[DIV_STEPS].v.quo;
  end

  assign p_rdy           = !p_v_r || crdy[0];
  assign drdy[DIV_STEPS] = p_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_rdy) begin
      p_v_r <= dv[DIV_STEPS];
    end
    if (p_rdy && dv[DIV_STEPS]) begin
      p_d_r <= p_d_nxt;
    end
  end

  // CORDIC chain: one rotation per cell for both lanes.
  assign cv[0] = p_v_r;
  assign cd[0] = p_d_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    svg_cordic_cell #(.STEP(k)) u_cordic_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_ready (crdy[k]),
      .up_data  (cd[k]),
      .dn_valid (cv[k+1]),
      .dn_ready (crdy[k+1]),
      .dn_data  (cd[k+1])
    );
  end

  // Rounding stage: Q2.30 down to Q2.15, half up, undoing the fold.
  function automatic logic signed [TRIG_W-1:0] round15(input logic signed [XY_W-1:0] a,
                                                      input logic flip);
    logic signed [XY_W:0]     s;
    logic signed [TRIG_W-1:0] r;
    s = (XY_W + 1)'(a) + (XY_W + 1)'(16384);
    s = s >>> 15;
    r = s[TRIG_W-1:0];
    return flip ? -r : r;
  endfunction

  logic                     t_v_r;
  logic                     t_rdy;
  logic signed [TRIG_W-1:0] sp_r, cp_r, st_r, ct_r;
  logic [TEX_W-1:0]         t_u_r, t_v_tex_r;
  logic                     m_rdy;

  assign t_rdy                = !t_v_r || m_rdy;
  assign crdy[CORDIC_STEPS]   = t_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (t_rdy) begin
      t_v_r <= cv[CORDIC_STEPS];
    end
    if (t_rdy && cv[CORDIC_STEPS]) begin
      sp_r      <= round15(cd[CORDIC_STEPS].phi.y, cd[CORDIC_STEPS].phi.flip);
      cp_r      <= round15(cd[CORDIC_STEPS].phi.x, cd[CORDIC_STEPS].phi.flip);
      st_r      <= round15(cd[CORDIC_STEPS].th.y, cd[CORDIC_STEPS].th.flip);
      ct_r      <= round15(cd[CORDIC_STEPS].th.x, cd[CORDIC_STEPS].th.flip);
      t_u_r     <= cd[CORDIC_STEPS].u;
      t_v_tex_r <= cd[CORDIC_STEPS].v;
    end
  end

  // Normal stage: nx = cos phi cos theta, nz = -sin phi cos theta.
  localparam int unsigned PROD_W = 2 * TRIG_W + 1;
  logic                     m_v_r;
  logic signed [TRIG_W-1:0] nx_r, ny_r, nz_r;
  logic signed [NRM_W-1:0]  tanx_r, tanz_r, biny_r;
  logic [TEX_W-1:0]         m_u_r, m_v_tex_r;
  logic signed [PROD_W-1:0] pxc, pzc;
  logic                     o_rdy;

  always_comb begin
    pxc = PROD_W'(cp_r * ct_r) + PROD_W'(16384);
    pzc = -PROD_W'(sp_r * ct_r) + PROD_W'(16384);
    pxc = pxc >>> 15;
    pzc = pzc >>> 15;
  end

  assign m_rdy = !m_v_r || o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_rdy) begin
      m_v_r <= t_v_r;
    end
    if (m_rdy && t_v_r) begin
      nx_r      <= pxc[TRIG_W-1:0];
      ny_r      <= st_r;
      nz_r      <= pzc[TRIG_W-1:0];
      tanx_r    <= sat16(WIDE_W'(-sp_r));
      tanz_r    <= sat16(WIDE_W'(-cp_r));
      biny_r    <= sat16(WIDE_W'(ct_r));
      m_u_r     <= t_u_r;
      m_v_tex_r <= t_v_tex_r;
    end
  end

  // Position stage and output register: normal times radius, rounded and
  // saturated to Q8.15.
  function automatic logic signed [POS_W-1:0] scale(input logic signed [TRIG_W-1:0] n,
                                                    input logic [RAD_W-1:0] r);
    logic signed [WIDE_W-1:0] p;
    p = WIDE_W'(n) * WIDE_W'(signed'({1'b0, r}));
    p = (p + WIDE_W'(32768)) >>> 16;
    return sat24(p);
  endfunction

  logic                    o_v_r;
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic signed [NRM_W-1:0] onx_r, ony_r, onz_r, otx_r, otz_r, oby_r;
  logic [TEX_W-1:0]        ou_r, ov_r;

  assign o_rdy = !o_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= m_v_r;
    end
    if (o_rdy && m_v_r) begin
      px_r  <= scale(nx_r, radius_r);
      py_r  <= scale(ny_r, radius_r);
      pz_r  <= scale(nz_r, radius_r);
      onx_r <= sat16(WIDE_W'(nx_r));
      ony_r <= sat16(WIDE_W'(ny_r));
      onz_r <= sat16(WIDE_W'(nz_r));
      otx_r <= tanx_r;
      otz_r <= tanz_r;
      oby_r <= biny_r;
      ou_r  <= m_u_r;
      ov_r  <= m_v_tex_r;
    end
  end

  assign out_ch.valid    = o_v_r;
  assign out_ch.pos_x    = px_r;
  assign out_ch.pos_y    = py_r;
  assign out_ch.pos_z    = pz_r;
  assign out_ch.norm_x   = onx_r;
  assign out_ch.norm_y   = ony_r;
  assign out_ch.norm_z   = onz_r;
  assign out_ch.tex_u    = ou_r;
  assign out_ch.tex_v    = ov_r;
  assign out_ch.tan_x    = otx_r;
  assign out_ch.tan_z    = otz_r;
  assign out_ch.binorm_y = oby_r;

endmodule

/* rtl/svg_checker.sv */
// Port-level checks of the sphere vertex generator and their bind statement.
// Depends on svg_pkg and sphere_vertex_generator_core.
`timescale 1ns / 1ps

module svg_checker import svg_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] out_pos_x,
  input logic [TEX_W-1:0]        out_tex_u,
  input logic [TEX_W-1:0]        out_tex_v
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An empty output register means every stage can move, so input is open.
  a_open_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // Texture coordinates never exceed 1.0.
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_u <= TEX_W'(65536)) && (out_tex_v <= TEX_W'(65536)))
    else $error("texture coordinate above one");

  // A stalled vertex holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_tex_u))
    else $error("stalled vertex changed");

endmodule

bind sphere_vertex_generator_core svg_checker u_svg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pos_x (out_ch.pos_x),
  .out_tex_u (out_ch.tex_u),
  .out_tex_v (out_ch.tex_v)
);
